/* rtl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and operation codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int KIND_W = 2;
   localparam int WORD_W = 32;
   localparam int OCC_W  = 11;

   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type           popped_value;
      logic               underflow;
      logic               overflow;
      logic [OCC_W-1:0]   occupancy;
      logic               is_empty;
      word_type           front_value;
      word_type           back_value;
   } rsp_type;

endpackage

/* rtl/bdq_mem.sv */
// ----------------------------------------------------------------------------
// bdq_mem
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdq_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  bdq_pkg::word_type        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output bdq_pkg::word_type        rd_data
);
   import bdq_pkg::*;

   word_type mem [DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bdq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdq_ctrl
// Pointer, count and end-word control; issues store accesses per request.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
   parameter int DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bdq_pkg::KIND_W-1:0]   req_kind,
   input  bdq_pkg::word_type            req_value,
   output logic                         mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]     mem_wr_addr,
   output bdq_pkg::word_type            mem_wr_data,
   output logic                         mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]     mem_rd_addr,
   input  bdq_pkg::word_type            mem_rd_data,
   output logic                         rsp_fire,
   output bdq_pkg::rsp_type             rsp_next
);
   import bdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   word_type      front_ff, front_in;
   word_type      back_ff, back_in;
   word_type      popped_ff, popped_in;
   logic          pend_ff, pend_in;
   logic          pend_front_ff, pend_front_in;

   logic                accept;
   logic                empty;
   logic                full;
   logic                under;
   logic                over;
   word_type            popped_now;
   logic [CW+OCC_W-1:0] occ_wide;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == LAST) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? LAST : p - AW'(1);
   endfunction

   assign busy   = pend_ff;
   assign accept = start && !pend_ff;
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == FULL);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      pend_in       = 1'b0;
      pend_front_in = pend_front_ff;
      under         = 1'b0;
      over          = 1'b0;
      popped_now    = '0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = head_ff;
      mem_wr_data   = req_value;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = head_ff;

      if (pend_ff) begin
         // read of the new end word has landed
         if (pend_front_ff) begin
            front_in = mem_rd_data;
         end else begin
            back_in = mem_rd_data;
         end
      end else if (accept) begin
         case (req_kind)
            KIND_PUSH_FRONT: begin
               if (full) begin
                  over = 1'b1;
               end else begin
                  head_in     = ptr_dec(head_ff);
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = ptr_dec(head_ff);
                  count_in    = count_ff + CW'(1);
                  front_in    = req_value;
                  if (empty) begin
                     tail_in = ptr_dec(head_ff);
                     back_in = req_value;
                  end
               end
            end
            KIND_PUSH_BACK: begin
               if (full) begin
                  over = 1'b1;
               end else begin
                  tail_in     = empty ? head_ff : ptr_inc(tail_ff);
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = empty ? head_ff : ptr_inc(tail_ff);
                  count_in    = count_ff + CW'(1);
                  back_in     = req_value;
                  if (empty) begin
                     front_in = req_value;
                  end
               end
            end
            KIND_POP_FRONT: begin
               if (empty) begin
                  under = 1'b1;
               end else begin
                  popped_now = front_ff;
                  head_in    = ptr_inc(head_ff);
                  count_in   = count_ff - CW'(1);
                  if (count_ff == CW'(2)) begin
                     front_in = back_ff;
                  end else if (count_ff != CW'(1)) begin
                     mem_rd_en     = 1'b1;
                     mem_rd_addr   = ptr_inc(head_ff);
                     pend_in       = 1'b1;
                     pend_front_in = 1'b1;
                  end
               end
            end
            KIND_POP_BACK: begin
               if (empty) begin
                  under = 1'b1;
               end else begin
                  popped_now = back_ff;
                  tail_in    = ptr_dec(tail_ff);
                  count_in   = count_ff - CW'(1);
                  if (count_ff == CW'(2)) begin
                     back_in = front_ff;
                  end else if (count_ff != CW'(1)) begin
                     mem_rd_en     = 1'b1;
                     mem_rd_addr   = ptr_dec(tail_ff);
                     pend_in       = 1'b1;
                     pend_front_in = 1'b0;
                  end
               end
            end
            default: begin
               under = 1'b0;
            end
         endcase
      end
   end

   assign popped_in = pend_in ? popped_now : popped_ff;
   assign rsp_fire  = pend_ff || (accept && !pend_in);
   assign occ_wide  = {{OCC_W{1'b0}}, count_in};

   always_comb begin
      rsp_next.popped_value = pend_ff ? popped_ff : popped_now;
      rsp_next.underflow    = under;
      rsp_next.overflow     = over;
      rsp_next.occupancy    = occ_wide[OCC_W-1:0];
      rsp_next.is_empty     = (count_in == '0);
      rsp_next.front_value  = (count_in == '0) ? '0 : front_in;
      rsp_next.back_value   = (count_in == '0) ? '0 : back_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      popped_ff     <= popped_in;
      pend_front_ff <= pend_front_in;
   end

endmodule

/* rtl/bounded_deque.sv */
// ----------------------------------------------------------------------------
// bounded_deque
// Bounded double-ended queue of signed 32-bit words in a circular store.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. req_kind
// selects push front, push back, pop front or pop back; req_value is the
// word to push. Each request gives exactly one result, shown on the rsp_
// ports for one cycle with rsp_valid high; the receiver cannot stall it.
// Pushes, rejected pushes (overflow), pops on an empty queue (underflow) and
// pops that leave at most one word give their result in the cycle after the
// request, and the next request can follow in the next cycle. A pop that
// leaves two or more words must fetch the new end word from the store:
// busy is high for one cycle while the word goes into the store's read
// register, then into the result register; no request is taken meanwhile.
// The end words are held in registers, so only this fetch holds pops back.
// Reset clears the head, tail and count, making the queue empty; store
// contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_deque #(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [bdq_pkg::KIND_W-1:0] req_kind,
   input  bdq_pkg::word_type          req_value,
   output logic                       rsp_valid,
   output bdq_pkg::word_type          rsp_popped_value,
   output logic                       rsp_underflow,
   output logic                       rsp_overflow,
   output logic [bdq_pkg::OCC_W-1:0]  rsp_occupancy,
   output logic                       rsp_is_empty,
   output bdq_pkg::word_type          rsp_front_value,
   output bdq_pkg::word_type          rsp_back_value
);
   import bdq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   word_type      mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   word_type      mem_rd_data;
   logic          rsp_fire;
   rsp_type       rsp_next;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   bdq_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bdq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_kind    (req_kind),
      .req_value   (req_value),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rsp_fire    (rsp_fire),
      .rsp_next    (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_ff.popped_value;
   assign rsp_underflow    = rsp_ff.underflow;
   assign rsp_overflow     = rsp_ff.overflow;
   assign rsp_occupancy    = rsp_ff.occupancy;
   assign rsp_is_empty     = rsp_ff.is_empty;
   assign rsp_front_value  = rsp_ff.front_value;
   assign rsp_back_value   = rsp_ff.back_value;

   // every accepted request either answers next cycle or holds busy
   a_req_progress : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor pending");

   // a pending store read finishes with a result in the next cycle
   a_fetch_done : assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("pending fetch did not complete");

   // an empty queue reports no end words
   a_empty_ends : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |->
         (rsp_occupancy == '0 && rsp_front_value == '0 && rsp_back_value == '0))
      else $error("empty result carries end words");

   // underflow and overflow never together, and underflow pops nothing
   a_flags : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_underflow) |-> (!rsp_overflow && rsp_popped_value == '0))
      else $error("inconsistent underflow result");

endmodule
